/* rtl/ilid_pkg.sv */
// shared types and constants for the indexed list
package ilid_pkg;

  localparam int unsigned IDX_W = 11;
  localparam int unsigned GRP_SIZE = 8;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_DELETE = 3'd1,
    FN_READ   = 3'd2,
    FN_WRITE  = 3'd3,
    FN_PUSH   = 3'd4,
    FN_POP    = 3'd5,
    FN_RESIZE = 3'd6,
    FN_NOP    = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  position;
    logic [31:0] value;
    logic [6:0]  new_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  length;
  } rsp_t;

endpackage

/* rtl/indexed_list_insert_delete.sv */
// top level of the indexed list with insert and delete by position
//
// Ordered list of up to CAPACITY elements held in a row of cells; every
// cell loads new data or takes its left or right neighbor, so insert,
// delete, write, push, pop and resize finish in the cycle the request is
// taken and their result shows on the next cycle, with busy staying low.
// A read in range also passes S_READ: the element is picked via a two-stage
// registered select tree, and busy is high for the one cycle in between; a
// read out of range finishes like the other requests.
// Every accepted request gives exactly one result, marked by result_valid_o
// for one cycle; the receiver cannot stall it. Errors leave the list unchanged.
module indexed_list_insert_delete
  import ilid_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic result_valid_o,
  output rsp_t result_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] CapW = IDX_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic result_valid_q, result_valid_d;
  rsp_t result_q, result_d;

  cmd_t cmd;
  logic accept;
  logic [IDX_W-1:0] pos_w, cnt_w, nlen_w, len_after;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic [ELEM_WIDTH-1:0] cells [CAPACITY];
  logic [ELEM_WIDTH-1:0] rd_data;
  status_e st;
  logic go_read;

  assign accept  = start && !busy;
  assign busy    = (state_q == S_READ);
  assign pos_w   = IDX_W'(req_i.position);
  assign nlen_w  = IDX_W'(req_i.new_length);
  assign cnt_w   = IDX_W'(count_q);
  assign wr_data = ELEM_WIDTH'(req_i.value);

  always_comb begin
    cmd.kind = CMD_NONE;
    cmd.pos  = pos_w;
    cmd.cnt  = cnt_w;
    st       = ST_OK;
    count_d  = count_q;
    go_read  = 1'b0;
    if (accept) begin
      unique case (func_e'(req_i.func))
        FN_INSERT: begin
          if (pos_w > cnt_w) begin
            st = ST_RANGE;
          end else if (cnt_w == CapW) begin
            st = ST_FULL;
          end else begin
            cmd.kind = CMD_INSERT;
            count_d  = count_q + 1'b1;
          end
        end
        FN_PUSH: begin
          cmd.pos = cnt_w;
          if (cnt_w == CapW) begin
            st = ST_FULL;
          end else begin
            cmd.kind = CMD_INSERT;
            count_d  = count_q + 1'b1;
          end
        end
        FN_DELETE: begin
          if (cnt_w == '0) begin
            st = ST_EMPTY;
          end else if (pos_w >= cnt_w) begin
            st = ST_RANGE;
          end else begin
            cmd.kind = CMD_DELETE;
            count_d  = count_q - 1'b1;
          end
        end
        FN_POP: begin
          cmd.pos = cnt_w - 1'b1;
          if (cnt_w == '0) begin
            st = ST_EMPTY;
          end else begin
            cmd.kind = CMD_DELETE;
            count_d  = count_q - 1'b1;
          end
        end
        FN_READ: begin
          if (pos_w >= cnt_w) st = ST_RANGE;
          else go_read = 1'b1;
        end
        FN_WRITE: begin
          if (pos_w >= cnt_w) st = ST_RANGE;
          else cmd.kind = CMD_WRITE;
        end
        FN_RESIZE: begin
          if (nlen_w > CapW) st = ST_RANGE;
          else count_d = CNT_W'(nlen_w);
        end
        default: st = ST_OK;
      endcase
    end
  end

  assign len_after = IDX_W'(count_d);

  always_comb begin
    state_d        = state_q;
    result_valid_d = 1'b0;
    result_d       = result_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && go_read) begin
          state_d = S_READ;
        end else if (accept) begin
          result_valid_d      = 1'b1;
          result_d.status     = st;
          result_d.read_value = '0;
          result_d.length     = len_after[6:0];
        end
      end
      S_READ: begin
        state_d             = S_IDLE;
        result_valid_d      = 1'b1;
        result_d.status     = ST_OK;
        result_d.read_value = 32'(rd_data);
        result_d.length     = cnt_w[6:0];
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cells[i+1];
    end
    ilid_cell #(
      .IDX        (i),
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .data_i  (wr_data),
      .left_i  (left),
      .right_i (right),
      .value_o (cells[i])
    );
  end

  ilid_read_tree #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_read_tree (
    .clk_i     (clk_i),
    .capture_i (accept && go_read),
    .pos_i     (pos_w),
    .cells_i   (cells),
    .data_o    (rd_data)
  );

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

/* rtl/ilid_cell.sv */
// one list element: holds, loads new data or shifts from a neighbor
module ilid_cell
  import ilid_pkg::*;
#(
  parameter int unsigned IDX        = 0,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [ELEM_WIDTH-1:0] data_i,
  input  logic [ELEM_WIDTH-1:0] left_i,
  input  logic [ELEM_WIDTH-1:0] right_i,
  output logic [ELEM_WIDTH-1:0] value_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);
  localparam logic [IDX_W:0]   MyIdxNext = (IDX_W + 1)'(IDX + 1);

  logic [ELEM_WIDTH-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (cmd_i.kind)
      CMD_WRITE: begin
        if (MyIdx == cmd_i.pos) value_d = data_i;
      end
      CMD_INSERT: begin
        if (MyIdx == cmd_i.pos) begin
          value_d = data_i;
        end else if (MyIdx > cmd_i.pos && MyIdx <= cmd_i.cnt) begin
          value_d = left_i;
        end
      end
      CMD_DELETE: begin
        if (MyIdx >= cmd_i.pos && MyIdxNext < {1'b0, cmd_i.cnt}) value_d = right_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

/* rtl/ilid_read_tree.sv */
// two-stage select of one element by index; the group stage is registered
module ilid_read_tree
  import ilid_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  capture_i,
  input  logic [IDX_W-1:0]      pos_i,
  input  logic [ELEM_WIDTH-1:0] cells_i [CAPACITY],
  output logic [ELEM_WIDTH-1:0] data_o
);

  localparam int unsigned NGrp = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  logic [ELEM_WIDTH-1:0] grp_q [NGrp];
  logic [ELEM_WIDTH-1:0] grp_d [NGrp];

  always_comb begin
    for (int g = 0; g < NGrp; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < CAPACITY) begin
          if (pos_i == IDX_W'(g * GRP_SIZE + k)) grp_d[g] = grp_d[g] | cells_i[g * GRP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    data_o = '0;
    for (int g = 0; g < NGrp; g++) begin
      data_o = data_o | grp_q[g];
    end
  end

endmodule
